/* rtl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, command and state codes and control bundles of the
// free-block bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

   localparam int NUM_BLOCKS_DEF      = 65536;
   localparam int RESERVED_BLOCKS_DEF = 8;
   localparam int MAP_WORD_BITS_DEF   = 64;

   localparam int CMD_W     = 2;
   localparam int ID_W      = 16;
   localparam int GRP_WORDS = 32;
   localparam int GRP_SEL_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_REQUEST = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_WORD,
      ST_READ,
      ST_MODIFY
   } state_type;

   typedef struct packed {
      logic search;
      logic upd;
      logic upd_full;
   } flag_ctl_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

endpackage

/* rtl/fba_req_if.sv */
// ----------------------------------------------------------------------------
// fba_req_if
// Command channel: valid/ready handshake with command code and block index.
// ----------------------------------------------------------------------------
interface fba_req_if import fba_pkg::*; ();

   logic            valid;
   logic            ready;
   logic [CMD_W-1:0] cmd;
   logic [ID_W-1:0]  target_blk;

   modport source (output valid, output cmd, output target_blk, input ready);
   modport sink   (input valid, input cmd, input target_blk, output ready);

endinterface

/* rtl/fba_rsp_if.sv */
// ----------------------------------------------------------------------------
// fba_rsp_if
// Result channel: valid/ready handshake with status and block index.
// ----------------------------------------------------------------------------
interface fba_rsp_if import fba_pkg::*; ();

   logic            valid;
   logic            ready;
   logic            ok;
   logic [ID_W-1:0] granted_block;

   modport source (output valid, output ok, output granted_block, input ready);
   modport sink   (input valid, input ok, input granted_block, output ready);

endinterface

/* rtl/fba_flag_search.sv */
// ----------------------------------------------------------------------------
// fba_flag_search
// Per-word full flags with a two-level first-fit search: a registered group
// pick followed by a word pick inside the chosen group of 32 words.
// ----------------------------------------------------------------------------
module fba_flag_search import fba_pkg::*; #(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
   parameter int MAP_WORD_BITS   = MAP_WORD_BITS_DEF,
   localparam int MAP_WORDS  = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
   localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
   localparam int NGRP       = (MAP_WORDS + GRP_WORDS - 1) / GRP_WORDS,
   localparam int GRP_W      = (NGRP > 1) ? $clog2(NGRP) : 1,
   localparam int SLOT_W     = GRP_W + GRP_SEL_W
) (
   input  logic              clock,
   input  logic              reset,
   input  flag_ctl_type      ctl,
   input  logic [ADDR_W-1:0] upd_addr,
   output logic              grp_found,
   output logic              word_found,
   output logic [SLOT_W-1:0] word_idx
);

   localparam int NGRPS      = 1 << GRP_W;
   localparam int SLOTS      = NGRPS * GRP_WORDS;
   localparam int FULL_WORDS = RESERVED_BLOCKS / MAP_WORD_BITS;

   logic [SLOTS-1:0]     full_ff;
   logic [SLOTS-1:0]     full_rst;
   logic [NGRPS-1:0]     grp_full;
   logic [GRP_W-1:0]     grp_first;
   logic                 grp_any;
   logic [GRP_W-1:0]     grp_ff;
   logic [GRP_W-1:0]     grp_in;
   logic                 grp_found_ff;
   logic                 grp_found_in;
   logic [GRP_WORDS-1:0] slice;
   logic [GRP_SEL_W-1:0] sel;

   // reserved words and padding past the map count as full
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         full_rst[s] = (s < FULL_WORDS) || (s >= MAP_WORDS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= full_rst;
      end else if (ctl.upd) begin
         full_ff[SLOT_W'(upd_addr)] <= ctl.upd_full;
      end
   end

   always_comb begin
      grp_first = '0;
      grp_any   = 1'b0;
      for (int g = 0; g < NGRPS; g++) begin
         grp_full[g] = &full_ff[g*GRP_WORDS +: GRP_WORDS];
      end
      for (int g = NGRPS - 1; g >= 0; g--) begin
         if (!grp_full[g]) begin
            grp_first = GRP_W'(g);
            grp_any   = 1'b1;
         end
      end
   end

   always_comb begin
      grp_in       = ctl.search ? grp_first : grp_ff;
      grp_found_in = ctl.search ? grp_any : grp_found_ff;
   end

   always_ff @(posedge clock) begin
      grp_ff       <= grp_in;
      grp_found_ff <= grp_found_in;
   end

   always_comb begin
      slice = full_ff[grp_ff*GRP_WORDS +: GRP_WORDS];
      sel   = '0;
      for (int i = GRP_WORDS - 1; i >= 0; i--) begin
         if (!slice[i]) begin
            sel = GRP_SEL_W'(i);
         end
      end
   end

   assign grp_found  = grp_found_ff;
   assign word_found = ~&slice;
   assign word_idx   = {grp_ff, sel};

endmodule

/* rtl/fba_map_store.sv */
// ----------------------------------------------------------------------------
// fba_map_store
// Single-port bitmap memory with registered read data and a clearing pass
// that writes the reset pattern into every word after reset.
// ----------------------------------------------------------------------------
module fba_map_store import fba_pkg::*; #(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
   parameter int MAP_WORD_BITS   = MAP_WORD_BITS_DEF,
   localparam int MAP_WORDS  = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
   localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mem_ctl_type              ctl,
   input  logic [ADDR_W-1:0]        addr,
   input  logic [MAP_WORD_BITS-1:0] wr_data,
   output logic [MAP_WORD_BITS-1:0] rd_data,
   output logic                     busy
);

   localparam int FULL_WORDS = RESERVED_BLOCKS / MAP_WORD_BITS;
   localparam int PART_BITS  = RESERVED_BLOCKS % MAP_WORD_BITS;

   logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] rd_data_ff;
   logic                     clr_active_ff;
   logic                     clr_active_in;
   logic [ADDR_W-1:0]        clr_addr_ff;
   logic [ADDR_W-1:0]        clr_addr_in;
   logic [MAP_WORD_BITS-1:0] clr_word;

   always_comb begin
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         clr_word[i] = (int'(clr_addr_ff) < FULL_WORDS) ||
                       ((int'(clr_addr_ff) == FULL_WORDS) && (i < PART_BITS));
      end
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(MAP_WORDS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= clr_word;
      end else if (ctl.wr) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

endmodule

/* rtl/free_block_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_core
// First-fit free-block bitmap allocator with allocate, request and release.
// ----------------------------------------------------------------------------
// After reset the block writes the reset pattern into every map word, one
// word per cycle, and takes its first command only after that pass. Each
// command then runs alone through the sequencer states: an allocate passes
// through locate (group pick of the two-level full-flag search), word (word
// pick), read and modify, skipping read when no map word has a free bit; a
// request or release passes through locate, read and modify; an out-of-range
// request or release or an unused code goes from locate straight to modify.
// The read-modify-write of one map word goes through the single memory
// port. A result waits in an output register, so the next command is taken
// while it is still pending; a command only stalls in its modify state if the
// previous result has not been transferred yet.
module free_block_bitmap_allocator_core import fba_pkg::*; #(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
   parameter int MAP_WORD_BITS   = MAP_WORD_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   fba_req_if.sink   req_ch,
   fba_rsp_if.source rsp_ch
);

   localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int NGRP      = (MAP_WORDS + GRP_WORDS - 1) / GRP_WORDS;
   localparam int GRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int SLOT_W    = GRP_W + GRP_SEL_W;
   localparam int IDX_W     = ADDR_W + BIT_W;
   localparam int RNG_W     = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
   localparam int DIV_SH    = ID_W + BIT_W;
   localparam int PROD_W    = DIV_SH + ID_W;
   localparam longint RECIP = ((64'd1 << DIV_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

   state_type state_ff;
   state_type state_in;

   logic [CMD_W-1:0]         cmd_ff;
   logic [ID_W-1:0]          id_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [BIT_W-1:0]         bit_ff;
   logic                     fail_ff;
   logic [CMD_W-1:0]         cmd_in;
   logic [ID_W-1:0]          id_in;
   logic [ADDR_W-1:0]        addr_in;
   logic [BIT_W-1:0]         bit_in;
   logic                     fail_in;

   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   logic [ID_W-1:0]          rsp_block_ff;
   logic                     rsp_valid_in;
   logic                     rsp_ok_in;
   logic [ID_W-1:0]          rsp_block_in;

   logic                     is_alloc;
   logic                     in_range;
   logic                     loc_fail;
   logic [PROD_W-1:0]        div_prod;
   logic [ID_W-1:0]          quot;
   logic [ID_W-1:0]          quot_back;
   logic [ID_W-1:0]          rem_full;

   flag_ctl_type             flag_ctl;
   mem_ctl_type              mem_ctl;
   logic                     grp_found;
   logic                     word_found;
   logic [SLOT_W-1:0]        word_idx;
   logic [MAP_WORD_BITS-1:0] rd_data;
   logic                     map_busy;

   logic                     commit;
   logic [BIT_W-1:0]         zero_bit;
   logic                     zero_found;
   logic [BIT_W-1:0]         mod_bit;
   logic [MAP_WORD_BITS-1:0] mod_mask;
   logic [MAP_WORD_BITS-1:0] mod_word;
   logic                     mod_wr;
   logic                     mod_ok;
   logic [ID_W-1:0]          mod_block;
   logic [IDX_W-1:0]         alloc_blk;

   fba_flag_search #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .RESERVED_BLOCKS (RESERVED_BLOCKS),
      .MAP_WORD_BITS   (MAP_WORD_BITS)
   ) u_flags (
      .clock      (clock),
      .reset      (reset),
      .ctl        (flag_ctl),
      .upd_addr   (addr_ff),
      .grp_found  (grp_found),
      .word_found (word_found),
      .word_idx   (word_idx)
   );

   fba_map_store #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .RESERVED_BLOCKS (RESERVED_BLOCKS),
      .MAP_WORD_BITS   (MAP_WORD_BITS)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .addr    (addr_ff),
      .wr_data (mod_word),
      .rd_data (rd_data),
      .busy    (map_busy)
   );

   // block index split into word and bit by reciprocal multiply
   always_comb begin
      div_prod  = PROD_W'(id_ff) * PROD_W'(RECIP);
      quot      = div_prod[DIV_SH +: ID_W];
      quot_back = ID_W'(quot * MAP_WORD_BITS);
      rem_full  = id_ff - quot_back;
      is_alloc  = (cmd_ff == CMD_ALLOC);
      in_range  = (RNG_W'(id_ff) >= RNG_W'(RESERVED_BLOCKS)) &&
                  (RNG_W'(id_ff) < RNG_W'(NUM_BLOCKS));
      loc_fail  = !in_range || !((cmd_ff == CMD_REQUEST) || (cmd_ff == CMD_RELEASE));
   end

   // lowest clear bit of the word read back
   always_comb begin
      zero_bit   = '0;
      zero_found = 1'b0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!rd_data[i]) begin
            zero_bit   = BIT_W'(i);
            zero_found = 1'b1;
         end
      end
   end

   always_comb begin
      mod_bit   = is_alloc ? zero_bit : bit_ff;
      mod_mask  = MAP_WORD_BITS'(1) << mod_bit;
      alloc_blk = IDX_W'(addr_ff) * IDX_W'(MAP_WORD_BITS) + IDX_W'(zero_bit);
      mod_word  = rd_data | mod_mask;
      mod_wr    = 1'b0;
      mod_ok    = 1'b0;
      mod_block = id_ff;
      case (cmd_ff)
         CMD_ALLOC: begin
            mod_block = '0;
            if (!fail_ff && zero_found &&
                (RNG_W'(alloc_blk) < RNG_W'(NUM_BLOCKS))) begin
               mod_wr    = 1'b1;
               mod_ok    = 1'b1;
               mod_block = ID_W'(alloc_blk);
            end
         end
         CMD_REQUEST: begin
            if (!fail_ff && !(|(rd_data & mod_mask))) begin
               mod_wr = 1'b1;
               mod_ok = 1'b1;
            end
         end
         CMD_RELEASE: begin
            mod_word = rd_data & ~mod_mask;
            if (!fail_ff) begin
               mod_wr = 1'b1;
               mod_ok = 1'b1;
            end
         end
         default: begin
            mod_block = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!map_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            if (is_alloc) begin
               state_in = ST_WORD;
            end else if (loc_fail) begin
               state_in = ST_MODIFY;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_WORD: begin
            if (grp_found && word_found) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_MODIFY;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready      = 1'b0;
      commit            = 1'b0;
      mem_ctl           = '0;
      flag_ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_LOCATE: begin
            flag_ctl.search = is_alloc;
         end
         ST_READ: begin
            mem_ctl.rd = 1'b1;
         end
         ST_MODIFY: begin
            commit            = !rsp_valid_ff || rsp_ch.ready;
            mem_ctl.wr        = commit && mod_wr;
            flag_ctl.upd      = commit && mod_wr;
            flag_ctl.upd_full = &mod_word;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd_in  = cmd_ff;
      id_in   = id_ff;
      addr_in = addr_ff;
      bit_in  = bit_ff;
      fail_in = fail_ff;
      if (req_ch.valid && req_ch.ready) begin
         cmd_in = req_ch.cmd;
         id_in  = req_ch.target_blk;
      end
      if ((state_ff == ST_LOCATE) && !is_alloc) begin
         addr_in = ADDR_W'(quot);
         bit_in  = rem_full[BIT_W-1:0];
         fail_in = loc_fail;
      end
      if (state_ff == ST_WORD) begin
         addr_in = ADDR_W'(word_idx);
         fail_in = !(grp_found && word_found);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      id_ff   <= id_in;
      addr_ff <= addr_in;
      bit_ff  <= bit_in;
      fail_ff <= fail_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_block_in = rsp_block_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = mod_ok;
         rsp_block_in = mod_block;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = rsp_ok_ff;
   assign rsp_ch.granted_block = rsp_block_ff;

   // no command while the map is being cleared
   a_no_cmd_during_clear: assert property (
      @(posedge clock) disable iff (reset) map_busy |-> !req_ch.ready
   ) else $error("command taken during clearing pass");

   // every map write leaves a result behind
   a_write_gives_result: assert property (
      @(posedge clock) disable iff (reset) mem_ctl.wr |=> rsp_ch.valid
   ) else $error("map write without result");

   // one command at a time
   a_single_cmd: assert property (
      @(posedge clock) disable iff (reset)
         (req_ch.valid && req_ch.ready) |=> !req_ch.ready
   ) else $error("second command taken while one is in flight");

   // map word and its full flag change together
   a_flag_follows_map: assert property (
      @(posedge clock) disable iff (reset) mem_ctl.wr == flag_ctl.upd
   ) else $error("full flag out of step with map write");

endmodule
